>>> hw/rtl/shdlc_pkg.sv
package shdlc_pkg;

    // line bytes with special meaning
    localparam logic [7:0] MARK_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;

    // register map
    localparam int unsigned REG_MAX_PAYLOAD_LEN = 0;
    localparam logic [7:0]  MAX_LEN_RESET       = 8'hFF;

    // receive phases
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_HEAD  = 3'd1,
        PH_DATA  = 3'd2,
        PH_CHECK = 3'd3,
        PH_STOP  = 3'd4
    } phase_t;

    // end of frame status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ENC_ERR  = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_NO_STOP  = 3'd3,
        ST_BAD_SUM  = 3'd4
    } status_t;

    // result word kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // header positions
    localparam logic [1:0] HDR_ADDR  = 2'd0;
    localparam logic [1:0] HDR_CMD   = 2'd1;
    localparam logic [1:0] HDR_STATE = 2'd2;
    localparam logic [1:0] HDR_LEN   = 2'd3;

    // one result word
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] frame_addr;
        logic [7:0] frame_cmd;
        logic [7:0] device_state;
        logic [7:0] payload_len;
        status_t    status;
        logic       last;
    } result_t;

    // un-stuffing table for the byte after an escape
    function automatic logic [7:0] unstuff(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h31:   r = 8'h11;
            8'h33:   r = 8'h13;
            8'h5D:   r = 8'h7D;
            8'h5E:   r = 8'h7E;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/shdlc_skid.sv
module shdlc_skid
    import shdlc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // control: output register and one spare word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    // spare word only holds data behind a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held while output empty");

endmodule

>>> hw/rtl/shdlc_core.sv
module shdlc_core
    import shdlc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] rx_byte,
    input  logic [7:0] max_len,
    output logic       res_valid,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic       esc_reg, esc_next;
    logic [1:0] hidx_reg, hidx_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] state_reg, state_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] chk_reg, chk_next;

    logic       emit;
    logic [7:0] v;
    logic [7:0] cnt_inc;

    assign v       = esc_reg ? unstuff(rx_byte) : rx_byte;
    assign cnt_inc = cnt_reg + 8'd1;

    // next state and result for one word
    always_comb begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        hidx_next  = hidx_reg;
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        state_next = state_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        chk_next   = chk_reg;
        emit       = 1'b0;
        res        = '0;

        case (phase_reg)
            PH_HEAD, PH_DATA: begin
                if (esc_reg || (rx_byte != ESC_BYTE && rx_byte != MARK_BYTE)) begin
                    esc_next = 1'b0;
                    sum_next = sum_reg + v;
                    if (phase_reg == PH_HEAD) begin
                        case (hidx_reg)
                            HDR_ADDR:  addr_next  = v;
                            HDR_CMD:   cmd_next   = v;
                            HDR_STATE: state_next = v;
                            default:   len_next   = v;
                        endcase
                        if (hidx_reg != HDR_LEN) begin
                            hidx_next = hidx_reg + 2'd1;
                        end else begin
                            hidx_next = HDR_ADDR;
                            if (v > max_len) begin
                                // length over limit, report and hunt
                                phase_next       = PH_HUNT;
                                emit             = 1'b1;
                                res.kind         = KIND_END;
                                res.frame_addr   = addr_reg;
                                res.frame_cmd    = cmd_reg;
                                res.device_state = state_reg;
                                res.payload_len  = v;
                                res.status       = ST_TOO_LONG;
                                res.last         = 1'b1;
                            end else begin
                                cnt_next   = 8'd0;
                                phase_next = (v == 8'd0) ? PH_CHECK : PH_DATA;
                            end
                        end
                    end else begin
                        cnt_next = cnt_inc;
                        if (cnt_inc == len_reg) begin
                            phase_next = PH_CHECK;
                        end
                        emit          = 1'b1;
                        res.kind      = KIND_DATA;
                        res.data_byte = v;
                    end
                end else if (rx_byte == ESC_BYTE) begin
                    esc_next = 1'b1;
                end else begin
                    // unescaped marker: encoding error, marker opens next frame
                    emit             = 1'b1;
                    res.kind         = KIND_END;
                    res.frame_addr   = addr_reg;
                    res.frame_cmd    = cmd_reg;
                    res.device_state = state_reg;
                    res.payload_len  = len_reg;
                    res.status       = ST_ENC_ERR;
                    res.last         = 1'b1;
                    phase_next = PH_HEAD;
                    hidx_next  = HDR_ADDR;
                    addr_next  = 8'd0;
                    cmd_next   = 8'd0;
                    state_next = 8'd0;
                    len_next   = 8'd0;
                    cnt_next   = 8'd0;
                    sum_next   = 8'd0;
                    chk_next   = 8'd0;
                end
            end
            PH_CHECK: begin
                if (esc_reg) begin
                    chk_next   = unstuff(rx_byte);
                    esc_next   = 1'b0;
                    phase_next = PH_STOP;
                end else if (rx_byte == ESC_BYTE) begin
                    esc_next = 1'b1;
                end else begin
                    chk_next   = rx_byte;
                    phase_next = PH_STOP;
                end
            end
            PH_STOP: begin
                emit             = 1'b1;
                res.kind         = KIND_END;
                res.frame_addr   = addr_reg;
                res.frame_cmd    = cmd_reg;
                res.device_state = state_reg;
                res.payload_len  = len_reg;
                res.last         = 1'b1;
                if (rx_byte != MARK_BYTE) begin
                    res.status = ST_NO_STOP;
                    phase_next = PH_HUNT;
                end else if (~sum_reg != chk_reg) begin
                    // bad checksum: stop marker opens next frame
                    res.status = ST_BAD_SUM;
                    phase_next = PH_HEAD;
                    hidx_next  = HDR_ADDR;
                    addr_next  = 8'd0;
                    cmd_next   = 8'd0;
                    state_next = 8'd0;
                    len_next   = 8'd0;
                    cnt_next   = 8'd0;
                    sum_next   = 8'd0;
                    chk_next   = 8'd0;
                end else begin
                    res.status = ST_OK;
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                // hunting for the start marker
                if (rx_byte == MARK_BYTE) begin
                    phase_next = PH_HEAD;
                    esc_next   = 1'b0;
                    hidx_next  = HDR_ADDR;
                    addr_next  = 8'd0;
                    cmd_next   = 8'd0;
                    state_next = 8'd0;
                    len_next   = 8'd0;
                    cnt_next   = 8'd0;
                    sum_next   = 8'd0;
                    chk_next   = 8'd0;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    assign res_valid = in_valid && emit;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            esc_reg   <= 1'b0;
            hidx_reg  <= HDR_ADDR;
            addr_reg  <= 8'd0;
            cmd_reg   <= 8'd0;
            state_reg <= 8'd0;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            sum_reg   <= 8'd0;
            chk_reg   <= 8'd0;
        end else if (in_valid) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            hidx_reg  <= hidx_next;
            addr_reg  <= addr_next;
            cmd_reg   <= cmd_next;
            state_reg <= state_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            chk_reg   <= chk_next;
        end
    end

    // header position only moves while the header is being taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (hidx_reg != HDR_ADDR) |-> (phase_reg == PH_HEAD))
        else $error("header index set outside header phase");

    // pending escape only where escapes are decoded
    assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (phase_reg == PH_HEAD || phase_reg == PH_DATA || phase_reg == PH_CHECK))
        else $error("escape pending in wrong phase");

    // payload counter never passes the length byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (cnt_reg < len_reg))
        else $error("payload count beyond length");

endmodule

>>> hw/rtl/shdlc_frame_deframer.sv
// Receive deframer for a byte-stuffed frame link.
// s_axis: one raw line byte per word in s_tdata[7:0].
// m_axis: one word per payload byte (m_tuser = 0, m_tlast = 0) and one
// end of frame word (m_tuser = 1, m_tlast = 1) carrying the header bytes
// and a status: 0 ok, 1 encoding error, 2 too long, 3 missing stop,
// 4 checksum mismatch. Data of a frame that ends with a nonzero status
// is to be dropped by the consumer.
// APB register 0 (address 0): max_payload_len, reset 255, read back.
// The decoder updates its state in the cycle a byte is accepted; the
// result reaches m_* from the output register, or via the spare word.
// One byte per cycle while s_tready is high; bytes with no result just update state.
// Stall: a spare word behind the output register absorbs one result, so
// s_tready drops only after two results are held; nothing is lost.
// Reset (aresetn low, synchronous) empties the output side, returns the
// decoder to hunting for the start marker and the limit to 255.
module shdlc_frame_deframer
    import shdlc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // raw byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // decoded output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [7:0] data_byte, [15:8] frame_addr, [23:16] frame_cmd,
                                    // [31:24] device_state, [39:32] payload_len,
                                    // [42:40] status, [47:43] zero
    output logic        m_tuser,    // [0] kind
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] max_len_reg;
    logic       accept;
    logic       res_valid;
    logic       skid_ready;
    result_t    res;
    result_t    out_res;
    logic       sel_max_len;

    // configuration register
    assign pready      = 1'b1;
    assign sel_max_len = (paddr[2] == REG_MAX_PAYLOAD_LEN[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready && sel_max_len) begin
            max_len_reg <= pwdata[7:0];
        end
    end

    assign prdata = sel_max_len ? {24'd0, max_len_reg} : 32'd0;

    // input handshake
    assign s_tready = skid_ready;
    assign accept   = s_tvalid && skid_ready;

    shdlc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .rx_byte   (s_tdata),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    shdlc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (skid_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // pack the output word
    assign m_tdata = {5'd0, out_res.status, out_res.payload_len, out_res.device_state,
                      out_res.frame_cmd, out_res.frame_addr, out_res.data_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

>>> tb/shdlc_frame_deframer_test.sv
module shdlc_frame_deframer_test;
    import shdlc_pkg::*;

    // byte stuffing pairs on the line
    localparam logic [7:0] XON_BYTE  = 8'h11;
    localparam logic [7:0] XOFF_BYTE = 8'h13;
    localparam logic [7:0] XON_ESC   = 8'h31;
    localparam logic [7:0] XOFF_ESC  = 8'h33;
    localparam logic [7:0] ESC_ESC   = 8'h5D;
    localparam logic [7:0] MARK_ESC  = 8'h5E;

    localparam int NUM_PHASES   = 6;
    localparam int PHASE_BYTES  = 140;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;
    localparam int STUCK_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {
        FR_GOOD,
        FR_BAD_SUM,
        FR_NO_STOP,
        FR_CUT
    } frame_fault_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // raw line bytes waiting to be sent, decoded words still to arrive
    logic [7:0] line_q[$];
    result_t    decoded_q[$];

    // decoder copy
    phase_t     rx_phase;
    logic       esc_pend;
    logic [1:0] hdr_idx;
    logic [7:0] hdr_addr;
    logic [7:0] hdr_cmd;
    logic [7:0] hdr_state;
    logic [7:0] hdr_len;
    logic [7:0] data_cnt;
    logic [7:0] sum_acc;
    logic [7:0] rx_check;
    logic [7:0] len_limit;

    int errors        = 0;
    int words_checked = 0;
    int stuck_cycles  = 0;
    int gap_max       = 0;
    int stall_pct     = 0;
    int gap_left      = 0;
    int burst_left    = 0;
    int hold_armed    = 0;
    int hold_at       = 0;
    int hold_left     = 0;
    int queued        = 0;
    result_t got;

    shdlc_frame_deframer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // decoder prediction
    // ---------------------------------------------------------------

    function automatic logic [7:0] plain_of_escaped(input logic [7:0] b);
        case (b)
            XON_ESC:  return XON_BYTE;
            XOFF_ESC: return XOFF_BYTE;
            ESC_ESC:  return ESC_BYTE;
            MARK_ESC: return MARK_BYTE;
            default:  return b;
        endcase
    endfunction

    function automatic void start_frame();
        rx_phase  = PH_HEAD;
        esc_pend  = 1'b0;
        hdr_idx   = HDR_ADDR;
        hdr_addr  = '0;
        hdr_cmd   = '0;
        hdr_state = '0;
        hdr_len   = '0;
        data_cnt  = '0;
        sum_acc   = '0;
        rx_check  = '0;
    endfunction

    function automatic void reset_decoder();
        start_frame();
        rx_phase  = PH_HUNT;
        len_limit = MAX_LEN_RESET;
    endfunction

    function automatic void push_end(input status_t st);
        result_t w;
        w.kind         = KIND_END;
        w.data_byte    = '0;
        w.frame_addr   = hdr_addr;
        w.frame_cmd    = hdr_cmd;
        w.device_state = hdr_state;
        w.payload_len  = hdr_len;
        w.status       = st;
        w.last         = 1'b1;
        decoded_q.push_back(w);
    endfunction

    function automatic void push_data(input logic [7:0] v);
        result_t w;
        w              = '0;
        w.kind         = KIND_DATA;
        w.data_byte    = v;
        w.status       = ST_OK;
        decoded_q.push_back(w);
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic [7:0] v;
        logic       have_v;
        v      = b;
        have_v = 1'b0;
        case (rx_phase)
            PH_HEAD, PH_DATA: begin
                if (esc_pend) begin
                    v        = plain_of_escaped(b);
                    esc_pend = 1'b0;
                    have_v   = 1'b1;
                end else if (b == ESC_BYTE) begin
                    esc_pend = 1'b1;
                end else if (b == MARK_BYTE) begin
                    // marker inside a frame closes it and opens the next
                    push_end(ST_ENC_ERR);
                    start_frame();
                end else begin
                    have_v = 1'b1;
                end
                if (have_v) begin
                    sum_acc = sum_acc + v;
                    if (rx_phase == PH_HEAD) begin
                        case (hdr_idx)
                            HDR_ADDR:  hdr_addr  = v;
                            HDR_CMD:   hdr_cmd   = v;
                            HDR_STATE: hdr_state = v;
                            default:   hdr_len   = v;
                        endcase
                        if (hdr_idx != HDR_LEN) begin
                            hdr_idx = hdr_idx + 2'd1;
                        end else begin
                            hdr_idx = HDR_ADDR;
                            if (hdr_len > len_limit) begin
                                rx_phase = PH_HUNT;
                                push_end(ST_TOO_LONG);
                            end else begin
                                data_cnt = '0;
                                rx_phase = (hdr_len == 8'd0) ? PH_CHECK : PH_DATA;
                            end
                        end
                    end else begin
                        data_cnt = data_cnt + 8'd1;
                        if (data_cnt == hdr_len)
                            rx_phase = PH_CHECK;
                        push_data(v);
                    end
                end
            end
            PH_CHECK: begin
                // checksum byte is raw unless escaped
                if (esc_pend) begin
                    rx_check = plain_of_escaped(b);
                    esc_pend = 1'b0;
                    rx_phase = PH_STOP;
                end else if (b == ESC_BYTE) begin
                    esc_pend = 1'b1;
                end else begin
                    rx_check = b;
                    rx_phase = PH_STOP;
                end
            end
            PH_STOP: begin
                if (b != MARK_BYTE) begin
                    rx_phase = PH_HUNT;
                    push_end(ST_NO_STOP);
                end else if (~sum_acc != rx_check) begin
                    push_end(ST_BAD_SUM);
                    start_frame();
                end else begin
                    rx_phase = PH_HUNT;
                    push_end(ST_OK);
                end
            end
            default: begin
                if (b == MARK_BYTE)
                    start_frame();
                else
                    rx_phase = PH_HUNT;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // line byte generation
    // ---------------------------------------------------------------

    function automatic void put(input logic [7:0] b);
        line_q.push_back(b);
        queued++;
    endfunction

    // bias toward the bytes that matter to the stuffing
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 23))
            0:       return MARK_BYTE;
            1:       return ESC_BYTE;
            2:       return XON_BYTE;
            3:       return XOFF_BYTE;
            4:       return XON_ESC;
            5:       return XOFF_ESC;
            6:       return ESC_ESC;
            7:       return MARK_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // stuffed form of one frame byte, sometimes escaping a plain byte
    function automatic void put_stuffed(input logic [7:0] b);
        case (b)
            MARK_BYTE: begin
                put(ESC_BYTE);
                put(($urandom_range(0, 3) == 0) ? MARK_BYTE : MARK_ESC);
            end
            ESC_BYTE: begin
                put(ESC_BYTE);
                put(ESC_ESC);
            end
            XON_BYTE: begin
                put(ESC_BYTE);
                put(XON_ESC);
            end
            XOFF_BYTE: begin
                put(ESC_BYTE);
                put(XOFF_ESC);
            end
            default: begin
                if (b != XON_ESC && b != XOFF_ESC && b != ESC_ESC && b != MARK_ESC &&
                    $urandom_range(0, 15) == 0)
                    put(ESC_BYTE);
                put(b);
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_len(input logic [7:0] limit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'($urandom_range(0, (limit < 6) ? limit : 6));
        else if (r < 70)
            return 8'($urandom_range(0, (limit < 20) ? limit : 20));
        else if (r < 80)
            return (limit <= 40) ? limit : 8'($urandom_range(0, 40));
        else if (r < 92)
            return (limit < 8'hFF) ? limit + 8'd1 : 8'($urandom_range(0, 6));
        else
            return 8'($urandom_range(0, 40));
    endfunction

    function automatic void queue_frame(input logic [7:0] len, input frame_fault_t fault);
        logic [7:0] sum;
        logic [7:0] b;
        int         n;
        int         cut_at;
        sum    = '0;
        cut_at = $urandom_range(0, 3 + len);
        put(MARK_BYTE);
        for (n = 0; n < 4 + len; n++) begin
            if (fault == FR_CUT && n == cut_at) begin
                put(MARK_BYTE);
                return;
            end
            b   = (n == 3) ? len : pick_byte();
            sum = sum + b;
            put_stuffed(b);
        end
        b = ~sum;
        if (fault == FR_BAD_SUM)
            b = b ^ 8'($urandom_range(1, 255));
        if (b == ESC_BYTE || $urandom_range(0, 1) == 0)
            put_stuffed(b);
        else
            put(b);
        if (fault == FR_NO_STOP) begin
            b = 8'($urandom_range(0, 254));
            put((b == MARK_BYTE) ? 8'hFF : b);
        end else begin
            put(MARK_BYTE);
        end
    endfunction

    function automatic void queue_random(input int budget, input logic [7:0] limit);
        int start;
        int r;
        int k;
        start = queued;
        while (queued - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    put(pick_byte());
            end else if (r < 70) begin
                queue_frame(pick_len(limit), FR_GOOD);
            end else if (r < 78) begin
                queue_frame(pick_len(limit), FR_BAD_SUM);
            end else if (r < 86) begin
                queue_frame(pick_len(limit), FR_NO_STOP);
            end else begin
                queue_frame(pick_len(limit), FR_CUT);
            end
        end
    endfunction

    function automatic void queue_directed();
        // noise while hunting
        put(8'hFF);
        // escaped header bytes, escaped marker as data
        put(MARK_BYTE);
        put(ESC_BYTE); put(XON_ESC);
        put(ESC_BYTE); put(XOFF_ESC);
        put(ESC_BYTE); put(ESC_ESC);
        put(8'h01);
        put(ESC_BYTE); put(MARK_BYTE);
        put(8'hDF);
        put(MARK_BYTE);
        // marker in the header, then a zero length frame with a raw marker checksum
        put(MARK_BYTE);
        put(8'hFF);
        put(MARK_BYTE);
        put(8'h81); put(8'h00); put(8'h00); put(8'h00);
        put(MARK_BYTE);
        put(MARK_BYTE);
    endfunction

    // ---------------------------------------------------------------
    // byte driver
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            reset_decoder();
        end else begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (line_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= line_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result receiver and checker
    // ---------------------------------------------------------------

    // random stalls, plus one long hold-off when armed
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_armed != 0 && words_checked >= hold_at) begin
            hold_armed <= 0;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void check_word(input result_t want, input result_t seen,
                                       input logic [4:0] pad);
        if (seen.kind !== want.kind || seen.data_byte !== want.data_byte ||
            seen.frame_addr !== want.frame_addr || seen.frame_cmd !== want.frame_cmd ||
            seen.device_state !== want.device_state ||
            seen.payload_len !== want.payload_len || seen.status !== want.status ||
            seen.last !== want.last || pad !== 5'd0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("word %0d mismatch: expected kind %0d data %02h hdr %02h %02h %02h %02h",
                         words_checked, want.kind, want.data_byte, want.frame_addr,
                         want.frame_cmd, want.device_state, want.payload_len);
                $display("    status %0d last %0d; got kind %0d data %02h hdr %02h %02h %02h %02h",
                         want.status, want.last, seen.kind, seen.data_byte, seen.frame_addr,
                         seen.frame_cmd, seen.device_state, seen.payload_len);
                $display("    status %0d last %0d pad %02h", seen.status, seen.last, pad);
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.kind         = m_tuser;
            got.data_byte    = m_tdata[7:0];
            got.frame_addr   = m_tdata[15:8];
            got.frame_cmd    = m_tdata[23:16];
            got.device_state = m_tdata[31:24];
            got.payload_len  = m_tdata[39:32];
            got.status       = status_t'(m_tdata[42:40]);
            got.last         = m_tlast;
            if (decoded_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("word %0d arrived with nothing pending: kind %0d data %02h",
                             words_checked, got.kind, got.data_byte);
            end else begin
                check_word(decoded_q.pop_front(), got, m_tdata[47:43]);
            end
            words_checked++;
        end
    end

    // ---------------------------------------------------------------
    // watchdog
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (line_q.size() == 0 && !s_tvalid && decoded_q.size() == 0))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    // write the length limit and read it back
    task automatic set_len_limit(input logic [7:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * REG_MAX_PAYLOAD_LEN);
        pwdata  <= {24'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        len_limit = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {24'd0, v}) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("length limit read back %08h, expected %08h", prdata, {24'd0, v});
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every byte is taken and every word has come back
    task automatic drain();
        while (line_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int         ph;
        logic [7:0] limit;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin limit = MAX_LEN_RESET; gap_max = 3;  stall_pct = 30; end
                1: begin limit = 8'd0;          gap_max = 0;  stall_pct = 0;  end
                2: begin limit = 8'd8;          gap_max = 8;  stall_pct = 60; end
                3: begin limit = 8'hFF;         gap_max = 2;  stall_pct = 20; end
                4: begin limit = 8'd1;          gap_max = 0;  stall_pct = 0;  end
                default: begin limit = 8'd100;  gap_max = 12; stall_pct = 80; end
            endcase
            if (ph != 0)
                set_len_limit(limit);
            if (ph == 0)
                queue_directed();
            if (ph == 3) begin
                // long stall on the result side while bytes keep coming
                hold_at    = words_checked + 10;
                hold_armed = 1;
                queue_frame(8'hFF, FR_GOOD);
            end
            queue_random(PHASE_BYTES, limit);
            drain();
        end
        if (errors == 0 && decoded_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
